FILE: rtl/rbpd_pkg.sv
// ----------------------------------------------------------------------------
// rbpd_pkg
// Shared types, codes and arithmetic helpers for the RGBA block palette
// decoder.
// ----------------------------------------------------------------------------
package rbpd_pkg;

	// block queue between the front and back parts
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// format word: extended form when bits 6:4 are all set
	localparam logic [6:0] EXT_MARK = 7'h70;

	// alpha mode select in the extended form (bits 1:0)
	localparam logic [1:0] ASEL_SPLIT  = 2'd1;
	localparam logic [1:0] ASEL_NIBBLE = 2'd2;

	// alpha mode used whenever the format does not give one
	localparam logic [3:0] ALPHA_MODE_DFLT = 4'd3;

	// palette size codes: n = 2 << code
	localparam logic [1:0] SZ_2  = 2'd0;
	localparam logic [1:0] SZ_4  = 2'd1;
	localparam logic [1:0] SZ_8  = 2'd2;
	localparam logic [1:0] SZ_16 = 2'd3;

	// reciprocals for truncating division by n-1 (exact for numerators < 4096)
	localparam logic [24:0] RECIP_3  = 25'd2731; // >> 13
	localparam logic [24:0] RECIP_7  = 25'd4682; // >> 15
	localparam logic [24:0] RECIP_15 = 25'd4370; // >> 16

	localparam logic [3:0] LAST_POS = 4'd15;

	// index selection, mode bits 3:2
	typedef enum logic [1:0] {
		SEL_BLOCK4 = 2'd0, // 4-entry palette, one index for the block
		SEL_BLOCK  = 2'd1, // one index for the block
		SEL_QUAD   = 2'd2, // one index per 2x2 quad
		SEL_PIXEL  = 2'd3  // one index per pixel
	} sel_t;

	typedef struct packed {
		sel_t       sel;
		logic [1:0] szc;
	} mode_t;

	typedef struct packed {
		mode_t        cmode;
		mode_t        amode;
		logic [31:0]  ep_a;
		logic [31:0]  ep_b;
		logic [63:0]  cidx;
		logic [63:0]  aidx;
	} block_t;

	typedef struct packed {
		logic              valid;
		logic              full;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	function automatic mode_t mode_decode(input logic [3:0] m);
		mode_t r;
		r.sel = sel_t'(m[3:2]);
		r.szc = (sel_t'(m[3:2]) == SEL_BLOCK4) ? SZ_4 : m[1:0];
		return r;
	endfunction

	// floor(num / (n-1)), result always fits in 8 bits
	function automatic logic [7:0] span_div(input logic [11:0] num,
	                                        input logic [1:0] szc);
		logic [24:0] prod;
		logic [7:0]  q;
		prod = '0;
		q    = num[7:0];
		case (szc)
			SZ_2: begin
				q = num[7:0];
			end
			SZ_4: begin
				prod = {13'd0, num} * RECIP_3;
				q    = prod[20:13];
			end
			SZ_8: begin
				prod = {13'd0, num} * RECIP_7;
				q    = prod[22:15];
			end
			SZ_16: begin
				prod = {13'd0, num} * RECIP_15;
				q    = prod[23:16];
			end
			default: begin
				q = num[7:0];
			end
		endcase
		return q;
	endfunction

endpackage

FILE: rtl/rgba_block_palette_decoder_core.sv
// ----------------------------------------------------------------------------
// rgba_block_palette_decoder_core
// Decodes one encoded 4x4 endpoint-palette block into sixteen RGBA pixels.
// ----------------------------------------------------------------------------
// Each input transaction is one block; it produces sixteen output
// transactions, pixels 0..15 in raster order, last_pixel marking pixel 15.
// Throughput is one pixel per cycle while out_stall is low and a block is
// queued: the back part's pixel counter handles one pixel of the head block
// per cycle. The front decodes the format word and pushes the block into a
// two-entry queue; in_stall rises only when that queue is full, so the next
// block is taken while the current one is still being expanded. From the
// queue head, each pixel passes the numerator stage, then the divide-by-(n-1)
// stage, which is also the output register. out_stall holds the output
// register and any valid pixel behind it; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rgba_block_palette_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	// block input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] format_word,
	input  logic [31:0] endpoint_a,
	input  logic [31:0] endpoint_b,
	input  logic [63:0] colour_indices,
	input  logic [63:0] alpha_indices,
	// pixel output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  pixel_position,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last_pixel
);
	import rbpd_pkg::*;

	block_t  front_blk;
	block_t  head_blk;
	q_stat_t qstat;
	logic    push;
	logic    pop;

	// front: format decode, packing
	rbpd_front u_front (
		.format_word    (format_word),
		.endpoint_a     (endpoint_a),
		.endpoint_b     (endpoint_b),
		.colour_indices (colour_indices),
		.alpha_indices  (alpha_indices),
		.blk            (front_blk)
	);

	// input transaction completes whenever the queue has room
	assign in_stall = qstat.full;
	assign push     = in_valid && !in_stall;

	rbpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_blk),
		.pop    (pop),
		.dout   (head_blk),
		.stat   (qstat)
	);

	// back: per-pixel index pick, interpolation, division
	rbpd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head_blk),
		.head_valid     (qstat.valid),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_position (pixel_position),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.alpha          (alpha),
		.last_pixel     (last_pixel)
	);

	// queue never overfills
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCNT_W'(QDEPTH))
		else $error("block queue overfilled");

	// input is held off only when the queue is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (qstat.count == QCNT_W'(QDEPTH)))
		else $error("input stalled with room in queue");

	// no pop from an empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.valid)
		else $error("pop from empty block queue");

	// block end marker tracks the pixel number
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_pixel == (pixel_position == LAST_POS)))
		else $error("last_pixel out of step with pixel_position");

endmodule

FILE: rtl/rbpd_front.sv
// ----------------------------------------------------------------------------
// rbpd_front
// Classifies an incoming block: decodes the format word into color and
// alpha modes and packs the block for the queue.
// ----------------------------------------------------------------------------
module rbpd_front (
	input  logic [23:0]     format_word,
	input  logic [31:0]     endpoint_a,
	input  logic [31:0]     endpoint_b,
	input  logic [63:0]     colour_indices,
	input  logic [63:0]     alpha_indices,
	output rbpd_pkg::block_t blk
);
	import rbpd_pkg::*;

	logic       ext;
	logic [3:0] cm;
	logic [3:0] am;

	assign ext = (format_word[6:0] & EXT_MARK) == EXT_MARK;

	always_comb begin
		cm = format_word[3:0];
		am = ALPHA_MODE_DFLT;
		if (ext) begin
			cm = format_word[15:12];
			case (format_word[1:0])
				ASEL_SPLIT:  am = {format_word[15:14], format_word[11:10]};
				ASEL_NIBBLE: am = format_word[11:8];
				default:     am = ALPHA_MODE_DFLT;
			endcase
		end
	end

	always_comb begin
		blk.cmode = mode_decode(cm);
		blk.amode = mode_decode(am);
		blk.ep_a  = endpoint_a;
		blk.ep_b  = endpoint_b;
		blk.cidx  = colour_indices;
		blk.aidx  = alpha_indices;
	end

endmodule

FILE: rtl/rbpd_queue.sv
// ----------------------------------------------------------------------------
// rbpd_queue
// Short block queue between the front and back parts.
// ----------------------------------------------------------------------------
module rbpd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rbpd_pkg::block_t  din,
	input  logic              pop,
	output rbpd_pkg::block_t  dout,
	output rbpd_pkg::q_stat_t stat
);
	import rbpd_pkg::*;

	block_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

	assign dout       = mem_q[rd_ptr_q];
	assign stat.valid = cnt_q != '0;
	assign stat.full  = cnt_q == QCNT_W'(QDEPTH);
	assign stat.count = cnt_q;

endmodule

FILE: rtl/rbpd_back.sv
// ----------------------------------------------------------------------------
// rbpd_back
// Pixel sequencer: walks the head block pixel by pixel, forms the palette
// numerators (s1), divides by n-1 (s2, output register).
// ----------------------------------------------------------------------------
module rbpd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rbpd_pkg::block_t head,
	input  logic             head_valid,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [3:0]       pixel_position,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic             last_pixel
);
	import rbpd_pkg::*;

	logic [3:0]  pix_q;
	logic        adv;
	logic        s1_ready;
	logic        s2_ready;

	logic        vld_s1;
	logic [3:0]  pos_s1;
	logic [11:0] num_s1 [4];
	logic [1:0]  csz_s1;
	logic [1:0]  asz_s1;

	logic        vld_s2;
	logic [3:0]  pos_s2;
	logic [7:0]  chan_s2 [4];

	logic [3:0]  ck;
	logic [3:0]  ak;
	logic [3:0]  cmask;
	logic [3:0]  amask;
	logic [11:0] num [4];

	function automatic logic [3:0] pick_entry(input sel_t sel, input logic [3:0] p);
		logic [3:0] e;
		case (sel)
			SEL_PIXEL: e = p;
			SEL_QUAD:  e = {2'b00, p[3], p[1]};
			default:   e = 4'd0;
		endcase
		return e;
	endfunction

	function automatic logic [3:0] size_mask(input logic [1:0] szc);
		logic [4:0] n;
		n = 5'd2 << szc;
		return 4'(n - 5'd1);
	endfunction

	// (n-1-k)*a + k*b, at most 15*255
	function automatic logic [11:0] numer(input logic [3:0] nm1, input logic [3:0] k,
	                                      input logic [7:0] a, input logic [7:0] b);
		logic [3:0] wa;
		wa = nm1 - k;
		return ({8'd0, wa} * {4'd0, a}) + ({8'd0, k} * {4'd0, b});
	endfunction

	assign s2_ready = !vld_s2 || !out_stall;
	assign s1_ready = !vld_s1 || s2_ready;
	assign adv      = head_valid && s1_ready;
	assign pop      = adv && (pix_q == LAST_POS);

	always_comb begin
		cmask = size_mask(head.cmode.szc);
		amask = size_mask(head.amode.szc);
		ck    = head.cidx[4 * pick_entry(head.cmode.sel, pix_q) +: 4] & cmask;
		ak    = head.aidx[4 * pick_entry(head.amode.sel, pix_q) +: 4] & amask;
		for (int c = 0; c < 3; c++)
			num[c] = numer(cmask, ck, head.ep_a[8*c +: 8], head.ep_b[8*c +: 8]);
		num[3] = numer(amask, ak, head.ep_a[31:24], head.ep_b[31:24]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv)
				pix_q <= pix_q + 1'b1;
			if (s1_ready)
				vld_s1 <= adv;
			if (s2_ready)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1 <= pix_q;
			csz_s1 <= head.cmode.szc;
			asz_s1 <= head.amode.szc;
			for (int c = 0; c < 4; c++)
				num_s1[c] <= num[c];
		end
		if (s2_ready && vld_s1) begin
			pos_s2 <= pos_s1;
			for (int c = 0; c < 3; c++)
				chan_s2[c] <= span_div(num_s1[c], csz_s1);
			chan_s2[3] <= span_div(num_s1[3], asz_s1);
		end
	end

	assign out_valid      = vld_s2;
	assign pixel_position = pos_s2;
	assign red            = chan_s2[0];
	assign green          = chan_s2[1];
	assign blue           = chan_s2[2];
	assign alpha          = chan_s2[3];
	assign last_pixel     = pos_s2 == LAST_POS;

endmodule
